// ===== design/ppc_pkg.sv =====
// Shared types and codes for the polygon point containment block.
package ppc_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

endpackage

// ===== design/polygon_point_containment_top.sv =====
// Polygon point containment: vertex store, point-in-polygon and convexity test.
//
// A request is taken when start is high and busy is low; busy stays high until
// the single result has been presented. The result stands on status,
// inside_res, convex and vertex_count for exactly one cycle with done high and
// cannot be held off by the receiver. Vertices live in one synchronous memory
// read one entry per cycle. An add reads every stored vertex, a remove the
// entries above index. With N vertices stored a query makes N + 2 reads that
// walk the ring, then a three-stage difference / multiply / accumulate pipeline
// drains. A query on fewer than three vertices, a bad remove and an unused
// kind read no vertices.
module polygon_point_containment_top #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind,
  input  ppc_pkg::coord_t     x_coord,
  input  ppc_pkg::coord_t     y_coord,
  input  logic [2:0]          index,
  output logic                done,
  output logic [1:0]          status,
  output logic                inside_res,
  output logic                convex,
  output logic [3:0]          vertex_count
);

  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int CW   = $clog2(MAX_VERTICES + 3);
  localparam int IXW  = (NW > 3) ? NW : 3;
  localparam int CNTW = NW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // vertex memory
  ppc_pkg::vertex_t mem [MAX_VERTICES];
  ppc_pkg::vertex_t mem_q;
  logic             we;
  logic [AW-1:0]    wa;
  ppc_pkg::vertex_t wd;
  logic [AW-1:0]    ra;

  logic [1:0]       state;
  logic [1:0]       op;
  ppc_pkg::coord_t  px, py;
  logic [IXW-1:0]   idx_r;
  logic [NW-1:0]    count;

  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    rd_left;
  logic [CW-1:0]    rd_k;
  logic             r_vld;
  logic [CW-1:0]    r_k;
  logic [AW-1:0]    r_addr;

  // ring window: w1 = previous vertex, w2 = one before
  ppc_pkg::vertex_t w1, w2;

  logic             a_vld;
  logic [CW-1:0]    a_k;
  ppc_pkg::diff_t   x1, y1, x2, y2, ax, ay, bx, by;

  logic             b_vld;
  logic [CW-1:0]    b_k;
  ppc_pkg::prod_t   p_x1y2, p_y1x2, p_x1x2, p_y1y2, p_axby, p_aybx;
  logic             b_y1neg, b_y2neg;

  ppc_pkg::sum_t    cr, dt, trn;

  logic                   dup;
  logic                   left;
  logic                   on_edge;
  logic                   any_neg, any_pos;
  logic signed [CNTW-1:0] cnt;
  logic signed [CNTW-1:0] cnt_adj;

  logic [IXW-1:0]   idx_in;
  logic [IXW-1:0]   cnt_ix;
  logic [CW-1:0]    count_k;
  logic             pipe_empty;
  logic             full;
  logic             poly_ok;
  logic [NW-1:0]    count_next;
  logic [1:0]       status_next;
  logic [7:0]       count_wide;

  assign busy       = (state != S_IDLE);
  assign idx_in     = IXW'(index);
  assign cnt_ix     = IXW'(count);
  assign count_k    = CW'(count);
  assign pipe_empty = !r_vld && !a_vld && !b_vld;
  assign full       = (count == NW'(MAX_VERTICES));
  assign poly_ok    = (count >= NW'(3));
  assign ra         = rd_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q <= mem[ra];
  end

  // Shift-down writes trail the reads by one entry, so a read never hits a
  // pending write.
  always_comb begin
    we = 1'b0;
    wa = r_addr - AW'(1);
    wd = mem_q;
    if (state == S_RUN && r_vld && op == ppc_pkg::KIND_REMOVE) begin
      we = 1'b1;
    end else if (state == S_FIN && op == ppc_pkg::KIND_ADD && !dup && !full) begin
      we = 1'b1;
      wa = AW'(count);
      wd = '{x: px, y: py};
    end
  end

  // final accumulation terms
  always_comb begin
    cr  = ppc_pkg::sum_t'(p_x1y2) - ppc_pkg::sum_t'(p_y1x2);
    dt  = ppc_pkg::sum_t'(p_x1x2) + ppc_pkg::sum_t'(p_y1y2);
    trn = ppc_pkg::sum_t'(p_axby) - ppc_pkg::sum_t'(p_aybx);
  end

  always_comb begin
    cnt_adj     = left ? cnt : -cnt;
    count_next  = count;
    status_next = ppc_pkg::ST_DONE;
    unique case (op)
      ppc_pkg::KIND_ADD: begin
        if (dup) begin
          status_next = ppc_pkg::ST_DUP;
        end else if (full) begin
          status_next = ppc_pkg::ST_FULL;
        end else begin
          count_next = count + NW'(1);
        end
      end
      ppc_pkg::KIND_REMOVE: begin
        if (idx_r >= cnt_ix) begin
          status_next = ppc_pkg::ST_RANGE;
        end else begin
          count_next = count - NW'(1);
        end
      end
      default: begin
      end
    endcase
    count_wide = 8'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      done    <= 1'b0;
      r_vld   <= 1'b0;
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      rd_left <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op      <= kind;
            px      <= x_coord;
            py      <= y_coord;
            idx_r   <= idx_in;
            rd_k    <= '0;
            dup     <= 1'b0;
            left    <= 1'b0;
            on_edge <= 1'b0;
            any_neg <= 1'b0;
            any_pos <= 1'b0;
            cnt     <= '0;
            rd_addr <= '0;
            rd_left <= '0;
            state   <= S_RUN;
            unique case (kind)
              ppc_pkg::KIND_ADD: begin
                rd_left <= CW'(count);
              end
              ppc_pkg::KIND_REMOVE: begin
                if (idx_in < cnt_ix) begin
                  rd_addr <= AW'(idx_in + IXW'(1));
                  rd_left <= CW'(cnt_ix - idx_in - IXW'(1));
                end
              end
              ppc_pkg::KIND_QUERY: begin
                if (poly_ok) begin
                  rd_left <= CW'(count) + CW'(2);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          // read issue, one vertex per cycle, wrapping around the ring
          if (rd_left != '0) begin
            rd_left <= rd_left - CW'(1);
            rd_k    <= rd_k + CW'(1);
            rd_addr <= (NW'(rd_addr) == count - NW'(1)) ? '0 : rd_addr + AW'(1);
            r_vld   <= 1'b1;
            r_k     <= rd_k;
            r_addr  <= rd_addr;
          end else begin
            r_vld <= 1'b0;
          end

          // read data stage
          a_vld <= r_vld && op == ppc_pkg::KIND_QUERY;
          if (r_vld) begin
            if (op == ppc_pkg::KIND_ADD && mem_q.x == px && mem_q.y == py) begin
              dup <= 1'b1;
            end
            w1  <= mem_q;
            w2  <= w1;
            a_k <= r_k;
            x1  <= {w1.x[15], w1.x} - {px[15], px};
            y1  <= {w1.y[15], w1.y} - {py[15], py};
            x2  <= {mem_q.x[15], mem_q.x} - {px[15], px};
            y2  <= {mem_q.y[15], mem_q.y} - {py[15], py};
            ax  <= {w1.x[15], w1.x} - {w2.x[15], w2.x};
            ay  <= {w1.y[15], w1.y} - {w2.y[15], w2.y};
            bx  <= {mem_q.x[15], mem_q.x} - {w1.x[15], w1.x};
            by  <= {mem_q.y[15], mem_q.y} - {w1.y[15], w1.y};
          end

          // multiply stage
          b_vld <= a_vld;
          if (a_vld) begin
            b_k     <= a_k;
            p_x1y2  <= x1 * y2;
            p_y1x2  <= y1 * x2;
            p_x1x2  <= x1 * x2;
            p_y1y2  <= y1 * y2;
            p_axby  <= ax * by;
            p_aybx  <= ay * bx;
            b_y1neg <= y1[ppc_pkg::DIFF_W-1];
            b_y2neg <= y2[ppc_pkg::DIFF_W-1];
          end

          // accumulate stage; tag k is the ring position of the newest vertex
          if (b_vld) begin
            if (b_k == CW'(2)) begin
              left <= (trn > 0);
            end
            if (b_k != '0 && b_k <= count_k) begin
              if (cr == 0 && dt <= 0) begin
                on_edge <= 1'b1;
              end
              if (b_y1neg && !b_y2neg && cr > 0) begin
                cnt <= cnt + CNTW'(1);
              end else if (b_y2neg && !b_y1neg && cr < 0) begin
                cnt <= cnt - CNTW'(1);
              end
            end
            if (b_k >= CW'(3) && b_k <= count_k + CW'(1)) begin
              if (trn < 0) begin
                any_neg <= 1'b1;
              end
              if (trn > 0) begin
                any_pos <= 1'b1;
              end
            end
          end

          if (rd_left == '0 && pipe_empty) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          count        <= count_next;
          done         <= 1'b1;
          status       <= status_next;
          vertex_count <= count_wide[3:0];
          if (op == ppc_pkg::KIND_QUERY && poly_ok) begin
            inside_res <= on_edge || (cnt_adj > 0 && cnt_adj[0]);
            convex     <= left ? !any_neg : !any_pos;
          end else begin
            inside_res <= 1'b0;
            convex     <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
